// ===== design/assert_macros.svh =====
// Assertion macros used by the conditioner's top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk, with reset held off.
`define STP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define STP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/stp_pkg.sv =====
// Types, constants and lookup functions of the seat temperature sensor conditioner.
package stp_pkg;

  typedef struct packed {
    logic [9:0] sample;
    logic [6:0] ambient_temp;
    logic       other_faults;
    logic       machine_test;
    logic       pcb_test;
    logic       power_on;
  } stp_in_t;

  typedef struct packed {
    logic [9:0] filtered_value;
    logic [6:0] seat_temp;
    logic       sensor_fault;
    logic       over_temp;
    logic       alarm;
    logic       heater_on;
  } stp_out_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_FAULT_LOW  = 2'd0;
  localparam logic [1:0] REG_FAULT_HIGH = 2'd1;
  localparam logic [1:0] REG_OVER_TEMP  = 2'd2;

  localparam logic [9:0] FAULT_LOW_RESET  = 10'd30;
  localparam logic [9:0] FAULT_HIGH_RESET = 10'd994;
  localparam logic [6:0] OVER_TEMP_RESET  = 7'd55;

  localparam int unsigned WIN_DEPTH = 5;
  localparam logic [6:0]  TABLE_LEN = 7'd71;

  // Reciprocal of 3 scaled by 2**17; exact for every trimmed sum the window can give.
  localparam logic [16:0] RECIP3 = 17'd43691;
  localparam int unsigned RECIP3_SHIFT = 17;

  // Falling thermistor table, one entry per degree; zero past the end stops the walk.
  function automatic logic [9:0] deg_entry(input logic [6:0] t);
    logic [9:0] v;
    case (t)
      7'd0: v = 10'd745;  7'd1: v = 10'd736;  7'd2: v = 10'd727;  7'd3: v = 10'd718;
      7'd4: v = 10'd709;  7'd5: v = 10'd700;  7'd6: v = 10'd691;  7'd7: v = 10'd682;
      7'd8: v = 10'd672;  7'd9: v = 10'd663;  7'd10: v = 10'd653; 7'd11: v = 10'd644;
      7'd12: v = 10'd634; 7'd13: v = 10'd625; 7'd14: v = 10'd615; 7'd15: v = 10'd605;
      7'd16: v = 10'd595; 7'd17: v = 10'd586; 7'd18: v = 10'd576; 7'd19: v = 10'd566;
      7'd20: v = 10'd557; 7'd21: v = 10'd547; 7'd22: v = 10'd538; 7'd23: v = 10'd528;
      7'd24: v = 10'd518; 7'd25: v = 10'd509; 7'd26: v = 10'd499; 7'd27: v = 10'd490;
      7'd28: v = 10'd480; 7'd29: v = 10'd471; 7'd30: v = 10'd461; 7'd31: v = 10'd452;
      7'd32: v = 10'd443; 7'd33: v = 10'd434; 7'd34: v = 10'd425; 7'd35: v = 10'd416;
      7'd36: v = 10'd407; 7'd37: v = 10'd398; 7'd38: v = 10'd390; 7'd39: v = 10'd381;
      7'd40: v = 10'd373; 7'd41: v = 10'd365; 7'd42: v = 10'd356; 7'd43: v = 10'd348;
      7'd44: v = 10'd341; 7'd45: v = 10'd333; 7'd46: v = 10'd325; 7'd47: v = 10'd318;
      7'd48: v = 10'd311; 7'd49: v = 10'd303; 7'd50: v = 10'd296; 7'd51: v = 10'd289;
      7'd52: v = 10'd283; 7'd53: v = 10'd276; 7'd54: v = 10'd269; 7'd55: v = 10'd263;
      7'd56: v = 10'd257; 7'd57: v = 10'd251; 7'd58: v = 10'd245; 7'd59: v = 10'd239;
      7'd60: v = 10'd233; 7'd61: v = 10'd227; 7'd62: v = 10'd222; 7'd63: v = 10'd216;
      7'd64: v = 10'd211; 7'd65: v = 10'd206; 7'd66: v = 10'd201; 7'd67: v = 10'd196;
      7'd68: v = 10'd191; 7'd69: v = 10'd187; 7'd70: v = 10'd182;
      default: v = 10'd0;
    endcase
    return v;
  endfunction

  // Heater setpoint in degrees for the ambient temperature band.
  function automatic logic [6:0] setpoint_for(input logic [6:0] amb);
    logic [6:0] sp;
    if (amb < 7'd10) sp = 7'd36;
    else if (amb < 7'd15) sp = 7'd34;
    else if (amb < 7'd20) sp = 7'd32;
    else if (amb < 7'd25) sp = 7'd30;
    else sp = 7'd25;
    return sp;
  endfunction

endpackage

// ===== design/seat_temp_sensor_conditioner.sv =====
// Top level of the seat temperature sensor conditioner.
// One transfer on the input channel brings one thermistor sample and the heater control
// inputs, and yields exactly one result transfer. Samples are stored in a five-entry
// window memory; on every fifth sample the block reads the window back one entry per
// cycle, drops the largest and smallest values and divides the other three by three,
// and holds that value until the next window completes (it is zero after reset, which
// reads as a sensor fault). Every item then converts the held value to degrees by
// walking the 71-entry thermistor table one entry per cycle, saturating at 71. The walk
// ends at once when the held value is at or above the first table entry. An item that
// completes a window also passes through read-back, trim and divide; the read-back is
// bounded by the single read port of the window memory. One item is worked on at a
// time; the result sits in an output register, so a new item can be taken while the
// previous result still waits. The user must write the three limits through the
// APB-style port only while the block is idle; the block itself does not enforce this.
module seat_temp_sensor_conditioner (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  stp_pkg::stp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output stp_pkg::stp_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);
  import stp_pkg::*;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_TRIM = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_LOOK = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [2:0] LAST_SLOT = 3'(WIN_DEPTH - 1);
  localparam logic [2:0] RD_END    = 3'(WIN_DEPTH);

  logic [2:0]  state_r, state_nxt;

  // Configuration registers.
  logic [9:0]  fault_low_r;
  logic [9:0]  fault_high_r;
  logic [6:0]  over_temp_lim_r;

  // Window memory and its read port.
  logic [9:0]  win_mem [0:WIN_DEPTH-1];
  logic [9:0]  rd_data_r;
  logic [2:0]  rd_idx_r;
  logic        rd_vld_r;
  logic [2:0]  win_cnt_r;

  // Item in flight and datapath registers.
  stp_in_t     item_r;
  logic [12:0] sum_r;
  logic [9:0]  max_r;
  logic [9:0]  min_r;
  logic [11:0] trim_r;
  logic [9:0]  held_r;
  logic [6:0]  deg_r;
  logic        heater_r;

  // Output register.
  logic        out_valid_r;
  stp_out_t    out_data_r;

  logic        in_fire;
  logic        cfg_wr;
  logic        out_load;
  logic        walk_go;
  logic [28:0] div_prod;
  logic        sfault;
  logic        otemp;
  logic        anyf;
  logic        heater_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_load  = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // The table walk continues while the held value is still below the current entry.
  assign walk_go   = (deg_r < TABLE_LEN) && (held_r < deg_entry(deg_r));

  // Division by three as a multiply by the scaled reciprocal.
  assign div_prod  = {17'd0, trim_r} * {12'd0, RECIP3};

  // Flags and heater decision for the finishing item.
  assign sfault = (held_r < fault_low_r) || (held_r > fault_high_r);
  assign otemp  = ({1'b0, deg_r} >= {1'b0, over_temp_lim_r});
  assign anyf   = sfault || otemp || item_r.other_faults;

  always_comb begin
    heater_nxt = heater_r;
    if (!item_r.pcb_test && item_r.power_on && !anyf) begin
      heater_nxt = (deg_r <= setpoint_for(item_r.ambient_temp));
    end
  end

  // Configuration port: a write lands in the access phase; reads are combinational.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_FAULT_LOW:  cfg_prdata = {22'd0, fault_low_r};
      REG_FAULT_HIGH: cfg_prdata = {22'd0, fault_high_r};
      REG_OVER_TEMP:  cfg_prdata = {25'd0, over_temp_lim_r};
      default:        cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_low_r     <= FAULT_LOW_RESET;
      fault_high_r    <= FAULT_HIGH_RESET;
      over_temp_lim_r <= OVER_TEMP_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        REG_FAULT_LOW:  fault_low_r     <= cfg_pwdata[9:0];
        REG_FAULT_HIGH: fault_high_r    <= cfg_pwdata[9:0];
        REG_OVER_TEMP:  over_temp_lim_r <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  // Sequencer. A completed window detours through read-back, trim and divide before
  // the table walk; every other item goes straight to the walk.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire) state_nxt = (win_cnt_r == LAST_SLOT) ? S_READ : S_LOOK;
      end
      S_READ: begin
        if (rd_idx_r == RD_END && rd_vld_r) state_nxt = S_TRIM;
      end
      S_TRIM: state_nxt = S_DIV;
      S_DIV:  state_nxt = S_LOOK;
      S_LOOK: begin
        if (!walk_go) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // Window memory: written on the accepting edge, read back one entry per cycle.
  always_ff @(posedge clk) begin
    if (in_fire) win_mem[win_cnt_r] <= in_data.sample;
    if (state_r == S_READ && rd_idx_r < RD_END) rd_data_r <= win_mem[rd_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_cnt_r <= 3'd0;
      rd_idx_r  <= 3'd0;
      rd_vld_r  <= 1'b0;
      held_r    <= 10'd0;
      heater_r  <= 1'b0;
      deg_r     <= 7'd0;
    end else begin
      if (in_fire) begin
        win_cnt_r <= (win_cnt_r == LAST_SLOT) ? 3'd0 : win_cnt_r + 3'd1;
        rd_idx_r  <= 3'd0;
        rd_vld_r  <= 1'b0;
        deg_r     <= 7'd0;
      end
      if (state_r == S_READ) begin
        rd_vld_r <= (rd_idx_r < RD_END);
        if (rd_idx_r < RD_END) rd_idx_r <= rd_idx_r + 3'd1;
      end
      if (state_r == S_DIV) held_r <= div_prod[RECIP3_SHIFT +: 10];
      if (state_r == S_LOOK && walk_go) deg_r <= deg_r + 7'd1;
      if (out_load) heater_r <= heater_nxt;
    end
  end

  // Window statistics: the first returned entry seeds sum, maximum and minimum.
  always_ff @(posedge clk) begin
    if (in_fire) item_r <= in_data;
    if (state_r == S_READ && rd_vld_r) begin
      if (rd_idx_r == 3'd1) begin
        sum_r <= {3'd0, rd_data_r};
        max_r <= rd_data_r;
        min_r <= rd_data_r;
      end else begin
        sum_r <= sum_r + {3'd0, rd_data_r};
        if (rd_data_r > max_r) max_r <= rd_data_r;
        if (rd_data_r < min_r) min_r <= rd_data_r;
      end
    end
    if (state_r == S_TRIM) trim_r <= 12'(sum_r - {3'd0, max_r} - {3'd0, min_r});
  end

  // Output register: the slot empties on a transfer and fills as an item finishes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r.filtered_value <= held_r;
      out_data_r.seat_temp      <= deg_r;
      out_data_r.sensor_fault   <= sfault;
      out_data_r.over_temp      <= otemp;
      out_data_r.alarm          <= anyf && !item_r.machine_test;
      out_data_r.heater_on      <= heater_nxt;
    end
  end

  `include "assert_macros.svh"

  // The write pointer of the window never leaves the five slots.
  `STP_ASSERT(a_win_cnt_range, (win_cnt_r <= LAST_SLOT), "window count out of range")
  // The table walk stops at the saturation value.
  `STP_ASSERT(a_deg_range, (deg_r <= TABLE_LEN), "table walk ran past the end")
  // After a transfer in, the block is not ready in the cycle after it.
  `STP_ASSERT(a_busy_after_accept, in_fire |=> !in_ready, "accepted twice in a row")
  // The held value changes only out of the divide step.
  `STP_ASSERT(a_held_only_from_div, (!$stable(held_r)) |-> ($past(state_r) == S_DIV),
              "held value changed outside window completion")

endmodule

// ===== tb/seat_temp_sensor_conditioner_checker.sv =====
// Checker that watches the conditioner's channels, computes each reading and compares it.
`timescale 1ns / 100ps

module seat_temp_sensor_conditioner_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  stp_pkg::stp_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  stp_pkg::stp_out_t out_data,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [3:0]        cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  input  logic [31:0]       cfg_prdata,
  input  logic              cfg_pready,
  output int                mismatch_count,
  output int                readings_outstanding
);
  import stp_pkg::*;

  localparam int THERM_LEN = 71;

  // Falling thermistor curve, one entry per degree.
  logic [9:0] therm_curve [0:THERM_LEN-1] = '{
    10'd745, 10'd736, 10'd727, 10'd718, 10'd709, 10'd700, 10'd691, 10'd682, 10'd672, 10'd663,
    10'd653, 10'd644, 10'd634, 10'd625, 10'd615, 10'd605, 10'd595, 10'd586, 10'd576, 10'd566,
    10'd557, 10'd547, 10'd538, 10'd528, 10'd518, 10'd509, 10'd499, 10'd490, 10'd480, 10'd471,
    10'd461, 10'd452, 10'd443, 10'd434, 10'd425, 10'd416, 10'd407, 10'd398, 10'd390, 10'd381,
    10'd373, 10'd365, 10'd356, 10'd348, 10'd341, 10'd333, 10'd325, 10'd318, 10'd311, 10'd303,
    10'd296, 10'd289, 10'd283, 10'd276, 10'd269, 10'd263, 10'd257, 10'd251, 10'd245, 10'd239,
    10'd233, 10'd227, 10'd222, 10'd216, 10'd211, 10'd206, 10'd201, 10'd196, 10'd191, 10'd187,
    10'd182
  };

  // Shadow copy of the limits and the conditioning state.
  logic [9:0] lim_low;
  logic [9:0] lim_high;
  logic [6:0] lim_over;
  logic [9:0] win_buf [0:4];
  logic [2:0] win_fill;
  logic [9:0] held_mean;
  logic       heater_q;

  stp_out_t conditioned_q [$];
  int       err_total = 0;
  int       queued = 0;

  assign mismatch_count       = err_total;
  assign readings_outstanding = queued;

  function automatic logic [6:0] heater_setpoint(input logic [6:0] amb);
    if (amb < 7'd10) return 7'd36;
    if (amb < 7'd15) return 7'd34;
    if (amb < 7'd20) return 7'd32;
    if (amb < 7'd25) return 7'd30;
    return 7'd25;
  endfunction

  // Advances the shadow state by one sample and returns the reading it yields.
  function automatic stp_out_t condition_sample(input stp_in_t it);
    stp_out_t r;
    int       sum;
    int       hi;
    int       lo;
    int       deg;
    int       i;
    logic     sfault;
    logic     otemp;
    logic     anyf;
    if (win_fill > 3'd4) win_fill = 3'd0;
    win_buf[win_fill] = it.sample;
    win_fill = win_fill + 3'd1;
    if (win_fill >= 3'd5) begin
      win_fill = 3'd0;
      sum = 0;
      hi = int'(win_buf[0]);
      lo = int'(win_buf[0]);
      for (i = 0; i < 5; i++) begin
        if (int'(win_buf[i]) > hi) hi = int'(win_buf[i]);
        if (int'(win_buf[i]) < lo) lo = int'(win_buf[i]);
        sum += int'(win_buf[i]);
      end
      held_mean = 10'((sum - hi - lo) / 3);
    end
    deg = 0;
    while (deg < THERM_LEN && held_mean < therm_curve[deg]) deg++;
    sfault = (held_mean < lim_low) || (held_mean > lim_high);
    otemp  = (7'(deg) >= lim_over);
    anyf   = sfault || otemp || it.other_faults;
    if (!it.pcb_test && it.power_on && !anyf) begin
      heater_q = (7'(deg) <= heater_setpoint(it.ambient_temp));
    end
    r.filtered_value = held_mean;
    r.seat_temp      = 7'(deg);
    r.sensor_fault   = sfault;
    r.over_temp      = otemp;
    r.alarm          = anyf && !it.machine_test;
    r.heater_on      = heater_q;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_total++;
    end
  endtask

  always @(posedge clk) begin : watch
    stp_out_t want;
    if (!rst_n) begin
      lim_low   = FAULT_LOW_RESET;
      lim_high  = FAULT_HIGH_RESET;
      lim_over  = OVER_TEMP_RESET;
      for (int k = 0; k < 5; k++) win_buf[k] = '0;
      win_fill  = '0;
      held_mean = '0;
      heater_q  = 1'b0;
      conditioned_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pready) begin
        if (cfg_pwrite) begin
          case (cfg_paddr[3:2])
            REG_FAULT_LOW:  lim_low  = cfg_pwdata[9:0];
            REG_FAULT_HIGH: lim_high = cfg_pwdata[9:0];
            REG_OVER_TEMP:  lim_over = cfg_pwdata[6:0];
            default: ;
          endcase
        end else begin
          case (cfg_paddr[3:2])
            REG_FAULT_LOW:  check_field("fault_low_limit read", {22'd0, lim_low}, cfg_prdata);
            REG_FAULT_HIGH: check_field("fault_high_limit read", {22'd0, lim_high}, cfg_prdata);
            REG_OVER_TEMP:  check_field("over_temp_limit read", {25'd0, lim_over}, cfg_prdata);
            default: ;
          endcase
        end
      end
      if (out_valid && out_ready) begin
        if (conditioned_q.size() == 0) begin
          $display("%0t: unexpected reading, expected none, actual %h", $time, out_data);
          err_total++;
        end else begin
          want = conditioned_q.pop_front();
          check_field("filtered_value", 32'(want.filtered_value),
                      32'(out_data.filtered_value));
          check_field("seat_temp", 32'(want.seat_temp), 32'(out_data.seat_temp));
          check_field("sensor_fault", 32'(want.sensor_fault), 32'(out_data.sensor_fault));
          check_field("over_temp", 32'(want.over_temp), 32'(out_data.over_temp));
          check_field("alarm", 32'(want.alarm), 32'(out_data.alarm));
          check_field("heater_on", 32'(want.heater_on), 32'(out_data.heater_on));
        end
      end
      if (in_valid && in_ready) conditioned_q.push_back(condition_sample(in_data));
    end
    queued = conditioned_q.size();
  end

endmodule

// ===== tb/seat_temp_sensor_conditioner_tb.sv =====
// Testbench top: drives directed and random thermistor samples and limits, and gives the verdict.
`timescale 1ns / 100ps

module seat_temp_sensor_conditioner_tb;
  import stp_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 6;
  // A quiet stretch far beyond the longest time an item takes in the block is a hang.
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 100;
  localparam int NUM_PHASES     = 6;
  // Address slot past the last register; writes there must be ignored.
  localparam logic [1:0] REG_UNMAPPED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  stp_in_t     in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  stp_out_t    out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatch_count;
  int readings_outstanding;

  // Tracks the value last given to in_valid, so that it is never assigned twice in one step.
  bit in_held = 1'b0;
  // Random stalls on both sides; switched off for the last phase.
  bit idling_on = 1'b1;
  int ready_hold = 0;
  int quiet_cycles = 0;

  always #HALF_PERIOD clk = ~clk;

  seat_temp_sensor_conditioner dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  seat_temp_sensor_conditioner_checker checker_i (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_data              (in_data),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_data             (out_data),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready),
    .mismatch_count       (mismatch_count),
    .readings_outstanding (readings_outstanding)
  );

  // The receiver drops ready in bursts of random length. Ready may fall at any time,
  // so the bursts land on every phase of the block's work, including while a result waits.
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (idling_on && $urandom_range(0, 7) == 0) begin
      ready_hold = $urandom_range(1, 5) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // The watchdog restarts on any transfer or register access; a long quiet stretch means
  // the block has stopped taking samples or producing readings.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("** seat_temp_sensor_conditioner: FAILED **");
      $finish;
    end
  end

  // Lowers valid at the current falling edge, unless it is already low.
  task automatic stop_input();
    if (in_held) in_valid <= 1'b0;
    in_held = 1'b0;
  endtask

  // Offers one sample and returns at the falling edge after its transfer. Valid is left
  // high so that a following sample can go out back to back; any caller that lets time
  // pass without sending must call stop_input first.
  task automatic send_item(input stp_in_t item);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      stop_input();
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_held = 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_reading(input logic [9:0] sample, input logic [6:0] amb,
                              input logic other, input logic mtest, input logic pcb,
                              input logic power);
    stp_in_t item;
    item.sample       = sample;
    item.ambient_temp = amb;
    item.other_faults = other;
    item.machine_test = mtest;
    item.pcb_test     = pcb;
    item.power_on     = power;
    send_item(item);
  endtask

  // Holds off the sender until every reading owed by the block has been taken.
  task automatic wait_for_readings();
    stop_input();
    while (readings_outstanding != 0) @(negedge clk);
  endtask

  // One APB access: setup phase, then access phase until pready, then an idle phase.
  task automatic reg_access(input logic write, input logic [1:0] idx, input logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // Writes all three limits with random junk in the unused upper bits, then reads them back.
  // The block is idle here: every sample so far has had its reading taken.
  task automatic apply_limits(input logic [9:0] low, input logic [9:0] high,
                              input logic [6:0] over);
    logic [31:0] w;
    w = $urandom();
    w[9:0] = low;
    reg_access(1'b1, REG_FAULT_LOW, w);
    w = $urandom();
    w[9:0] = high;
    reg_access(1'b1, REG_FAULT_HIGH, w);
    w = $urandom();
    w[6:0] = over;
    reg_access(1'b1, REG_OVER_TEMP, w);
    reg_access(1'b0, REG_FAULT_LOW, '0);
    reg_access(1'b0, REG_FAULT_HIGH, '0);
    reg_access(1'b0, REG_OVER_TEMP, '0);
  endtask

  // One five-sample window. Most windows cluster around a level inside the thermistor
  // curve, so the mean lands where heater control and over-temperature matter; some carry
  // one outlier that trimming must reject, and the rest are noise or rail values.
  task automatic send_random_window();
    int          kind;
    int          base;
    int          outlier_at;
    logic [9:0]  s;
    int          n;
    kind = $urandom_range(0, 9);
    base = $urandom_range(170, 760);
    outlier_at = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 4) : -1;
    for (n = 0; n < 5; n++) begin
      if (kind <= 6) begin
        s = (n == outlier_at) ? 10'($urandom_range(0, 1023))
                              : 10'(base + $urandom_range(0, 20) - 10);
      end else if (kind <= 8) begin
        s = 10'($urandom_range(0, 1023));
      end else begin
        case ($urandom_range(0, 2))
          0: s = 10'd0;
          1: s = 10'd1023;
          default: s = 10'($urandom_range(0, 1023));
        endcase
      end
      send_reading(s, 7'($urandom_range(0, 71)),
                   $urandom_range(0, 7) == 0, $urandom_range(0, 3) == 0,
                   $urandom_range(0, 7) == 0, $urandom_range(0, 7) != 0);
    end
  endtask

  // Directed part: five windows covering the reset-time fault, rail samples, each setpoint
  // band, heater freeze by board test and by power off, the curve ends and both faults.
  task automatic run_directed();
    // Held mean is still zero, so every reading is a low sensor fault until this window
    // completes at a mean of 500 (26 degrees) and the heater turns on.
    send_reading(10'd1023, 7'd0,  1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd0,    7'd71, 1'b0, 1'b1, 1'b0, 1'b1);
    send_reading(10'd500,  7'd9,  1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd500,  7'd10, 1'b1, 1'b0, 1'b0, 1'b1);
    send_reading(10'd500,  7'd14, 1'b0, 1'b0, 1'b0, 1'b1);
    // At 26 degrees the heater follows the band: on, on, then off at ambient 25 and
    // frozen off under board test; the window ends at the top of the curve.
    send_reading(10'd745,  7'd15, 1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd745,  7'd20, 1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd745,  7'd25, 1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd745,  7'd24, 1'b0, 1'b0, 1'b1, 1'b1);
    send_reading(10'd745,  7'd19, 1'b0, 1'b0, 1'b0, 1'b0);
    // Zero degrees: heater on, frozen by board test and power off; the window ends at the
    // last curve entry, which is over-temperature at the reset limit.
    send_reading(10'd182,  7'd30, 1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd182,  7'd30, 1'b0, 1'b0, 1'b1, 1'b0);
    send_reading(10'd182,  7'd5,  1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd182,  7'd64, 1'b0, 1'b1, 1'b0, 1'b1);
    send_reading(10'd182,  7'd70, 1'b0, 1'b0, 1'b0, 1'b1);
    // Over-temperature with and without machine test; the window ends past the curve end,
    // where the degree reading saturates at 71.
    send_reading(10'd181,  7'd0,  1'b0, 1'b1, 1'b0, 1'b1);
    send_reading(10'd181,  7'd12, 1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd181,  7'd17, 1'b1, 1'b1, 1'b0, 1'b1);
    send_reading(10'd181,  7'd22, 1'b0, 1'b0, 1'b0, 1'b0);
    send_reading(10'd181,  7'd71, 1'b0, 1'b0, 1'b0, 1'b1);
    // Rails on both sides are trimmed away, leaving a mean just above the high fault limit.
    send_reading(10'd995,  7'd40, 1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd995,  7'd50, 1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd1023, 7'd60, 1'b0, 1'b1, 1'b0, 1'b1);
    send_reading(10'd995,  7'd3,  1'b0, 1'b0, 1'b0, 1'b1);
    send_reading(10'd0,    7'd8,  1'b0, 1'b0, 1'b0, 1'b1);
  endtask

  initial begin : stimulus
    int phase;
    int win;
    int windows;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    run_directed();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      wait_for_readings();
      case (phase)
        // Widest fault window and the top over-temperature limit.
        0: apply_limits(10'd0, 10'd1023, 7'd71);
        // Every mean is a sensor fault and every degree is over-temperature.
        1: apply_limits(10'd1023, 10'd0, 7'd0);
        // A limit above the curve range, so over-temperature never rises.
        2: apply_limits(10'd100, 10'd900, 7'd127);
        3: apply_limits(10'($urandom_range(0, 200)), 10'($urandom_range(800, 1023)),
                        7'($urandom_range(30, 71)));
        4: begin
          apply_limits(10'd50, 10'd950, 7'd40);
          // A write past the last register must leave every limit alone.
          reg_access(1'b1, REG_UNMAPPED, $urandom());
        end
        default: begin
          apply_limits(FAULT_LOW_RESET, FAULT_HIGH_RESET, OVER_TEMP_RESET);
          idling_on = 1'b0;
        end
      endcase
      windows = (phase == NUM_PHASES - 1) ? 35 : 38;
      for (win = 0; win < windows; win++) begin
        // Once mid-phase the sender waits until the block has handed back every reading.
        if (phase == 2 && win == 19) wait_for_readings();
        send_random_window();
      end
    end

    wait_for_readings();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && readings_outstanding == 0) begin
      $display("** seat_temp_sensor_conditioner: PASSED **");
    end else begin
      $display("** seat_temp_sensor_conditioner: FAILED **");
    end
    $finish;
  end

endmodule
